// ===== hdl/alsc_pkg.sv =====
// Package for the ambient light screen correction block.
// Field widths, register indexes, branch codes and fixed constants.
// No dependencies.
package alsc_pkg;

   localparam int BRIGHTNESS_BITS_DEF = 12;

   localparam int LIGHT_W = 23;
   localparam int COLOR_W = 8;
   localparam int LEVEL_W = 12;
   localparam int PEAK_W  = 16;
   localparam int BIAS_W  = 16;
   localparam int OUT_W   = 24;
   localparam int SUM_W   = 26;
   localparam int FRAC_BITS = 4;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int MIRROR_FLOOR = -64;
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;
   localparam int FULL_BRIGHTNESS_RESET = 1023;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RED_PEAK   = 3'd0,
      REG_GREEN_PEAK = 3'd1,
      REG_BLUE_PEAK  = 3'd2,
      REG_WHITE_PEAK = 3'd3,
      REG_FULL_LEVEL = 3'd4,
      REG_LEAK_BIAS  = 3'd5
   } csr_index_type;

   typedef enum logic [RSP_USER_W-1:0] {
      BR_SUBTRACT = 2'd0,
      BR_MIRRORED = 2'd1,
      BR_SCALED   = 2'd2,
      BR_CORRECTION = 2'd3
   } branch_type;

endpackage

// ===== hdl/alsc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The divisor must be held stable by the user while words are in flight.
// The block does not enforce this; a payload rides along. No dependencies.
module alsc_div #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 20,
   parameter int PAY_W = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [PAY_W-1:0] out_pay
);

   logic             vld_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] work_ff [NUM_W];
   logic [PAY_W-1:0] pay_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             vld_prev;
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] work_prev;
      logic [PAY_W-1:0] pay_prev;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] work_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign work_prev = in_num;
         assign pay_prev  = in_pay;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign work_prev = work_ff[k-1];
         assign pay_prev  = pay_ff[k-1];
      end

      assign trial   = {rem_prev, work_prev[NUM_W-1]};
      assign diff    = trial - {1'b0, den};
      assign ge      = (trial >= {1'b0, den});
      assign rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign work_in = {work_prev[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            pay_ff[k]  <= pay_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = work_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

endmodule

// ===== hdl/ambient_light_screen_correction.sv =====
// Top level of the ambient light screen correction block.
// Uses alsc_pkg and two alsc_div pipelined dividers.
//
// The req channel carries one word per sensor sample: the raw reading in
// 1/16 lux, the mean screen color above the sensor and the backlight level.
// The rsp channel returns one word per sample: the corrected reading in
// 1/16 lux, saturated to 24 bits, with the chosen branch in tuser.
// The csr port writes the calibration registers; writes are to be made by the
// user only while no sample is in flight; the block does not enforce this.
// A new word is accepted in every cycle while the skid register is empty.
// Most of the pipeline from acceptance to rsp_tvalid lies in the two
// bit-per-stage dividers: the brightness scaling divide and the white
// over color sum divide.
// Reset clears all valid bits and loads the register reset values, which leave
// the block without calibration so that the reading passes through unchanged.
// When the receiver stalls, a skid register takes one more word, then
// req_tready falls and the whole pipeline holds; nothing is lost or repeated.
module ambient_light_screen_correction #(
   parameter int BRIGHTNESS_BITS = alsc_pkg::BRIGHTNESS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // light_in[22:0], screen_red[30:23], screen_green[38:31],
   // screen_blue[46:39], panel_level[58:47], zeros above.
   input  logic [alsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // light_out[23:0].
   output logic [alsc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // branch_taken[1:0].
   output logic [alsc_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [alsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [alsc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import alsc_pkg::*;

   localparam int BB   = BRIGHTNESS_BITS;
   localparam int NW1  = SUM_W + FRAC_BITS + BB;
   localparam int DW1  = BB + 8;
   localparam int CW   = NW1 + 2;
   localparam int NW2  = CW + PEAK_W;
   localparam int DW2  = PEAK_W + 2;
   localparam int DDW  = CW + 1;
   localparam int EW   = NW2 + 2;
   localparam int PRW  = COLOR_W + PEAK_W;
   localparam int P1W  = LIGHT_W;
   localparam int P2W  = 1 + CW + LIGHT_W;

   // Calibration registers and values derived from them.
   logic [PEAK_W-1:0]  red_ff, green_ff, blue_ff, white_ff;
   logic [LEVEL_W-1:0] full_ff;
   logic [BIAS_W-1:0]  bias_ff;
   logic               cal_ff;
   logic [DW1-1:0]     den1_ff;
   logic [DW2-1:0]     den2_ff;
   logic [BB-1:0]      full_eff;
   logic [DW1-1:0]     den1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         white_ff <= '0;
         full_ff  <= LEVEL_W'(FULL_BRIGHTNESS_RESET);
         bias_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_RED_PEAK:   red_ff   <= csr_data[PEAK_W-1:0];
            REG_GREEN_PEAK: green_ff <= csr_data[PEAK_W-1:0];
            REG_BLUE_PEAK:  blue_ff  <= csr_data[PEAK_W-1:0];
            REG_WHITE_PEAK: white_ff <= csr_data[PEAK_W-1:0];
            REG_FULL_LEVEL: full_ff  <= csr_data[LEVEL_W-1:0];
            REG_LEAK_BIAS:  bias_ff  <= csr_data[BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   assign full_eff = (BB'(full_ff) == '0) ? BB'(1) : BB'(full_ff);
   assign den1_in  = {full_eff, 8'b0} - DW1'(full_eff);

   always_ff @(posedge clock) begin
      cal_ff  <= (red_ff != '0) && (green_ff != '0) && (blue_ff != '0) && (white_ff != '0);
      den1_ff <= den1_in;
      den2_ff <= DW2'(red_ff) + DW2'(green_ff) + DW2'(blue_ff);
   end

   // Pipeline control and output buffer.
   logic                  out_valid_ff, skid_valid_ff;
   logic [OUT_W-1:0]      out_data_ff, skid_data_ff;
   logic [RSP_USER_W-1:0] out_user_ff, skid_user_ff;
   logic                  adv, pop, push;
   logic                  last_valid;
   logic [OUT_W-1:0]      res_data;
   branch_type            res_branch;

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign pop        = out_valid_ff && rsp_tready;
   assign push       = adv && last_valid;

   // Stage 1: input capture.
   logic               v1_ff;
   logic [LIGHT_W-1:0] light1_ff;
   logic [COLOR_W-1:0] r1_ff, g1_ff, b1_ff;
   logic [BB-1:0]      lvl1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         light1_ff <= req_tdata[22:0];
         r1_ff     <= req_tdata[30:23];
         g1_ff     <= req_tdata[38:31];
         b1_ff     <= req_tdata[46:39];
         lvl1_ff   <= BB'(req_tdata[58:47]);
      end
   end

   // Stage 2: gray part and remaining color parts.
   logic               v2_ff;
   logic [LIGHT_W-1:0] light2_ff;
   logic [COLOR_W-1:0] m2_ff, dr2_ff, dg2_ff, db2_ff;
   logic [BB-1:0]      lvl2_ff;
   logic [COLOR_W-1:0] m_rg, m_in;

   assign m_rg = (r1_ff < g1_ff) ? r1_ff : g1_ff;
   assign m_in = (b1_ff < m_rg) ? b1_ff : m_rg;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         light2_ff <= light1_ff;
         m2_ff     <= m_in;
         dr2_ff    <= r1_ff - m_in;
         dg2_ff    <= g1_ff - m_in;
         db2_ff    <= b1_ff - m_in;
         lvl2_ff   <= lvl1_ff;
      end
   end

   // Stage 3: weight each part by its peak.
   logic               v3_ff;
   logic [LIGHT_W-1:0] light3_ff;
   logic [PRW-1:0]     pw3_ff, pr3_ff, pg3_ff, pb3_ff;
   logic [BB-1:0]      lvl3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         light3_ff <= light2_ff;
         pw3_ff    <= PRW'(m2_ff) * PRW'(white_ff);
         pr3_ff    <= PRW'(dr2_ff) * PRW'(red_ff);
         pg3_ff    <= PRW'(dg2_ff) * PRW'(green_ff);
         pb3_ff    <= PRW'(db2_ff) * PRW'(blue_ff);
         lvl3_ff   <= lvl2_ff;
      end
   end

   // Stage 4: leak sum.
   logic               v4_ff;
   logic [LIGHT_W-1:0] light4_ff;
   logic [SUM_W-1:0]   s4_ff;
   logic [BB-1:0]      lvl4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         light4_ff <= light3_ff;
         s4_ff     <= SUM_W'(pw3_ff) + SUM_W'(pr3_ff) + SUM_W'(pg3_ff) + SUM_W'(pb3_ff);
         lvl4_ff   <= lvl3_ff;
      end
   end

   // Stage 5: scale by level, in 1/16 lux.
   logic               v5_ff;
   logic [LIGHT_W-1:0] light5_ff;
   logic [NW1-1:0]     num5_ff;
   logic [NW1-FRAC_BITS-1:0] lvl_prod;

   assign lvl_prod = (NW1-FRAC_BITS)'(s4_ff) * (NW1-FRAC_BITS)'(lvl4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         light5_ff <= light4_ff;
         num5_ff   <= {lvl_prod, {FRAC_BITS{1'b0}}};
      end
   end

   // Divide by 255 times full brightness.
   logic               v6;
   logic [NW1-1:0]     q1;
   logic [P1W-1:0]     pay6;

   alsc_div #(
      .NUM_W (NW1),
      .DEN_W (DW1),
      .PAY_W (P1W)
   ) u_div_level (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v5_ff),
      .in_num    (num5_ff),
      .den       (den1_ff),
      .in_pay    (light5_ff),
      .out_valid (v6),
      .out_quot  (q1),
      .out_pay   (pay6)
   );

   // Stage 7: correction with bias.
   logic                 v7_ff;
   logic [LIGHT_W-1:0]   light7_ff;
   logic signed [CW-1:0] corr7_ff;
   logic signed [CW-1:0] bias_q4;

   assign bias_q4 = {{(CW-BIAS_W-FRAC_BITS){bias_ff[BIAS_W-1]}}, bias_ff,
                     {FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6;
      end
      if (adv) begin
         light7_ff <= pay6;
         corr7_ff  <= cal_ff ? ($signed({2'b00, q1}) + bias_q4) : '0;
      end
   end

   // Stage 8: magnitude and sign.
   logic                 v8_ff;
   logic [LIGHT_W-1:0]   light8_ff;
   logic signed [CW-1:0] corr8_ff;
   logic [CW-1:0]        mag8_ff;
   logic                 neg8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
      if (adv) begin
         light8_ff <= light7_ff;
         corr8_ff  <= corr7_ff;
         neg8_ff   <= corr7_ff[CW-1];
         mag8_ff   <= corr7_ff[CW-1] ? CW'(-corr7_ff) : CW'(corr7_ff);
      end
   end

   // Stage 9: times the white peak.
   logic               v9_ff;
   logic [P2W-1:0]     pay9_ff;
   logic [NW2-1:0]     prod9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= v8_ff;
      end
      if (adv) begin
         pay9_ff  <= {neg8_ff, corr8_ff, light8_ff};
         prod9_ff <= NW2'(mag8_ff) * NW2'(white_ff);
      end
   end

   // Divide by the sum of the color peaks.
   logic           v10;
   logic [NW2-1:0] q2;
   logic [P2W-1:0] pay10;

   alsc_div #(
      .NUM_W (NW2),
      .DEN_W (DW2),
      .PAY_W (P2W)
   ) u_div_white (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v9_ff),
      .in_num    (prod9_ff),
      .den       (den2_ff),
      .in_pay    (pay9_ff),
      .out_valid (v10),
      .out_quot  (q2),
      .out_pay   (pay10)
   );

   // Stage 10: signed scaled correction.
   logic                  v10_ff;
   logic [LIGHT_W-1:0]    light10_ff;
   logic signed [CW-1:0]  corr10_ff;
   logic signed [NW2:0]   scaled10_ff;
   logic signed [NW2:0]   q2_s;

   assign q2_s = $signed({1'b0, q2});

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (adv) begin
         v10_ff <= v10;
      end
      if (adv) begin
         light10_ff  <= pay10[LIGHT_W-1:0];
         corr10_ff   <= $signed(pay10[LIGHT_W+CW-1:LIGHT_W]);
         scaled10_ff <= !cal_ff ? '0 : (pay10[P2W-1] ? -q2_s : q2_s);
      end
   end

   // Stage 11: the two differences.
   logic                  v11_ff;
   logic signed [CW-1:0]  corr11_ff;
   logic signed [DDW-1:0] d11_ff;
   logic signed [EW-1:0]  e11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (adv) begin
         v11_ff <= v10_ff;
      end
      if (adv) begin
         corr11_ff <= corr10_ff;
         d11_ff    <= $signed({{(DDW-LIGHT_W){1'b0}}, light10_ff}) - DDW'(corr10_ff);
         e11_ff    <= $signed({{(EW-LIGHT_W){1'b0}}, light10_ff}) - EW'(scaled10_ff);
      end
   end

   assign last_valid = v11_ff;

   // Branch choice and saturation.
   logic signed [EW-1:0] res_wide;
   localparam logic signed [DDW-1:0] FLOOR_D = DDW'(MIRROR_FLOOR);
   localparam logic signed [EW-1:0]  MAX_E   = EW'(OUT_MAX);
   localparam logic signed [EW-1:0]  MIN_E   = EW'(OUT_MIN);

   always_comb begin
      if (!d11_ff[DDW-1]) begin
         res_wide   = EW'(d11_ff);
         res_branch = BR_SUBTRACT;
      end else if (d11_ff > FLOOR_D) begin
         res_wide   = -EW'(d11_ff);
         res_branch = BR_MIRRORED;
      end else if (!e11_ff[EW-1]) begin
         res_wide   = e11_ff;
         res_branch = BR_SCALED;
      end else begin
         res_wide   = EW'(corr11_ff);
         res_branch = BR_CORRECTION;
      end
      if (res_wide > MAX_E) begin
         res_data = OUT_W'(MAX_E);
      end else if (res_wide < MIN_E) begin
         res_data = OUT_W'(MIN_E);
      end else begin
         res_data = res_wide[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= res_data;
            skid_user_ff <= res_branch;
         end else begin
            out_data_ff <= res_data;
            out_user_ff <= res_branch;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !skid_valid_ff && !push) |=> !out_valid_ff)
      else $error("output word repeated after it was taken");

   a_subtract_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == BR_SUBTRACT) |-> !rsp_tdata[OUT_W-1])
      else $error("subtract branch gave a negative result");

   a_mirror_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == BR_MIRRORED) |->
      (rsp_tdata[OUT_W-1:6] == '0 && rsp_tdata[5:0] != '0))
      else $error("mirrored branch result out of range");
`endif

endmodule
